// File: rtl/round_robin_process_table_defines.svh
// Assertion macros for the round-robin process table
`ifndef ROUND_ROBIN_PROCESS_TABLE_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RRPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrpt_pkg.sv
// Package: types, constants and microcode ROM of the round-robin process table
`default_nettype none
package rrpt_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NUS_W  = $clog2(SLOTS + 1);
  localparam int TGT_W  = (SLOT_W > 3) ? SLOT_W : 3;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_YIELD   = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SS_FREE      = 3'd0,
    SS_IDLE      = 3'd1,
    SS_RUNNING   = 3'd2,
    SS_MARKED    = 3'd3,
    SS_DESTROYED = 3'd4
  } slot_st_t;

  typedef enum logic [2:0] {
    RS_CREATED     = 3'd0,
    RS_FULL        = 3'd1,
    RS_ALREADY     = 3'd2,
    RS_BLOCKED     = 3'd3,
    RS_DESTROYED   = 3'd4,
    RS_SWITCHED    = 3'd5,
    RS_NONE_RUN    = 3'd6,
    RS_NOT_CREATED = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] target_slot;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_id;
    logic       from_valid;
    logic [2:0] next_slot;
  } out_beat_t;

  typedef enum logic [2:0] {
    UP_DISPATCH = 3'd0,
    UP_CREATE   = 3'd1,
    UP_DESTROY  = 3'd2,
    UP_YINIT    = 3'd3,
    UP_YBUSY    = 3'd4,
    UP_YIDLE    = 3'd5
  } upc_t;

  typedef enum logic [2:0] {
    ACT_NOP     = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_DESTROY = 3'd2,
    ACT_YINIT   = 3'd3,
    ACT_YBUSY   = 3'd4,
    ACT_YIDLE   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    C_ALWAYS    = 2'd0,
    C_START     = 2'd1,
    C_BUSY_DONE = 2'd2,
    C_IDLE_DONE = 2'd3
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  nxt_t;
    upc_t  nxt_f;
  } ucode_t;

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    case (a)
      UP_DISPATCH: w = '{ACT_NOP,     C_START,     UP_DISPATCH, UP_DISPATCH};
      UP_CREATE:   w = '{ACT_CREATE,  C_ALWAYS,    UP_DISPATCH, UP_DISPATCH};
      UP_DESTROY:  w = '{ACT_DESTROY, C_ALWAYS,    UP_DISPATCH, UP_DISPATCH};
      UP_YINIT:    w = '{ACT_YINIT,   C_ALWAYS,    UP_YBUSY,    UP_YBUSY};
      UP_YBUSY:    w = '{ACT_YBUSY,   C_BUSY_DONE, UP_YIDLE,    UP_YBUSY};
      UP_YIDLE:    w = '{ACT_YIDLE,   C_IDLE_DONE, UP_DISPATCH, UP_YIDLE};
      default:     w = '{ACT_NOP,     C_ALWAYS,    UP_DISPATCH, UP_DISPATCH};
    endcase
    return w;
  endfunction

  function automatic upc_t kind_entry(logic [1:0] k);
    upc_t e;
    case (k)
      KIND_CREATE:  e = UP_CREATE;
      KIND_DESTROY: e = UP_DESTROY;
      KIND_YIELD:   e = UP_YINIT;
      default:      e = UP_DISPATCH;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: rtl/round_robin_process_table.sv
// Top level: microcoded round-robin process slot table
//
//  channel | ports                      | beat accepted
//  --------+----------------------------+-------------------------------
//  input   | start, busy, in_item       | rising edge with start & !busy
//  result  | out_strobe, out_item       | rising edge ending strobe cycle
//
// Create and destroy: result is registered from the step entered on accept.
// Yield: UP_YINIT, then a running scan and an idle scan with one slot read per
//   step; the single read port of the slot table sets the length of each scan.
// Reserved kind: accepted, no result, busy never rises.
// Synchronous active-low reset frees all slots; no clearing pass.
// Results are shown for one cycle and cannot be stalled.
`default_nettype none
module round_robin_process_table (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  rrpt_pkg::in_beat_t   in_item,
  output logic                 out_strobe,
  output rrpt_pkg::out_beat_t  out_item
);
  import rrpt_pkg::*;

`include "round_robin_process_table_defines.svh"

  slot_st_t          tab_r [SLOTS];
  logic [NUS_W-1:0]  nus_r, nus_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt, cnt_r, cnt_nxt, from_r, from_nxt;
  logic              found_r, found_nxt;
  in_beat_t          in_r, in_nxt;
  out_beat_t         out_r, out_nxt;
  logic              strobe_r, strobe_nxt;
  upc_t              upc_r, upc_nxt;

  ucode_t            ucw;
  logic [SLOT_W-1:0] rd_addr, wr_addr, ptr_inc, tgt_idx;
  logic [TGT_W-1:0]  tgt_ext;
  logic              tgt_ok;
  slot_st_t          rd_st, wr_data;
  logic              wr_en;
  logic              busy_hit, idle_hit, last, accept;
  logic              res_yield;

  assign busy       = (upc_r != UP_DISPATCH);
  assign accept     = start && !busy;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign ucw      = ucode_rom(upc_r);
  assign tgt_ext  = TGT_W'(in_r.target_slot);
  assign tgt_idx  = tgt_ext[SLOT_W-1:0];
  assign tgt_ok   = {1'b0, tgt_ext} < (TGT_W + 1)'(SLOTS);
  assign rd_addr  = (ucw.act == ACT_DESTROY) ? tgt_idx : ptr_r;
  assign rd_st    = tab_r[rd_addr];
  assign busy_hit = (rd_st == SS_RUNNING) || (rd_st == SS_MARKED);
  assign idle_hit = (rd_st == SS_IDLE);
  assign last     = (cnt_r == SLOT_W'(SLOTS - 1));
  assign ptr_inc  = (ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;

  assign res_yield = (out_r.status == RS_SWITCHED) || (out_r.status == RS_NONE_RUN);

  // sequencer
  always_comb begin
    upc_nxt = upc_r;
    case (ucw.cond)
      C_START:     upc_nxt = start ? kind_entry(in_item.kind) : UP_DISPATCH;
      C_BUSY_DONE: upc_nxt = (busy_hit || last) ? ucw.nxt_t : ucw.nxt_f;
      C_IDLE_DONE: upc_nxt = (idle_hit || last) ? ucw.nxt_t : ucw.nxt_f;
      C_ALWAYS:    upc_nxt = ucw.nxt_t;
      default:     upc_nxt = UP_DISPATCH;
    endcase
  end

  // datapath control
  always_comb begin
    nus_nxt    = nus_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    from_nxt   = from_r;
    found_nxt  = found_r;
    in_nxt     = accept ? in_item : in_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    wr_data    = SS_IDLE;
    case (ucw.act)
      ACT_CREATE: begin
        strobe_nxt = 1'b1;
        if (nus_r < NUS_W'(SLOTS)) begin
          wr_en   = 1'b1;
          wr_addr = nus_r[SLOT_W-1:0];
          wr_data = SS_IDLE;
          nus_nxt = nus_r + 1'b1;
          out_nxt = '{RS_CREATED, 3'(nus_r[SLOT_W-1:0]), 1'b0, 3'd0};
        end else begin
          out_nxt = '{RS_FULL, 3'd0, 1'b0, 3'd0};
        end
      end
      ACT_DESTROY: begin
        strobe_nxt = 1'b1;
        wr_addr    = tgt_idx;
        out_nxt    = '{RS_NOT_CREATED, in_r.target_slot, 1'b0, 3'd0};
        if (!tgt_ok || rd_st == SS_FREE) begin
          out_nxt.status = RS_NOT_CREATED;
        end else if (rd_st == SS_DESTROYED) begin
          out_nxt.status = RS_ALREADY;
        end else if (rd_st == SS_RUNNING) begin
          wr_en          = 1'b1;
          wr_data        = SS_MARKED;
          out_nxt.status = RS_BLOCKED;
        end else begin
          wr_en          = 1'b1;
          wr_data        = SS_DESTROYED;
          out_nxt.status = RS_DESTROYED;
        end
      end
      ACT_YINIT: begin
        ptr_nxt   = '0;
        cnt_nxt   = '0;
        from_nxt  = '0;
        found_nxt = 1'b0;
      end
      ACT_YBUSY: begin
        if (busy_hit) begin
          wr_en     = 1'b1;
          wr_data   = (rd_st == SS_MARKED) ? SS_DESTROYED : SS_IDLE;
          from_nxt  = ptr_r;
          found_nxt = 1'b1;
          ptr_nxt   = ptr_inc;
          cnt_nxt   = '0;
        end else if (last) begin
          ptr_nxt = '0;
          cnt_nxt = '0;
        end else begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ACT_YIDLE: begin
        if (idle_hit) begin
          wr_en      = 1'b1;
          wr_data    = SS_RUNNING;
          strobe_nxt = 1'b1;
          out_nxt    = '{RS_SWITCHED, 3'(from_r), found_r, 3'(ptr_r)};
        end else if (last) begin
          strobe_nxt = 1'b1;
          out_nxt    = '{RS_NONE_RUN, 3'(from_r), found_r, 3'd0};
        end else begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r    <= UP_DISPATCH;
      strobe_r <= 1'b0;
      nus_r    <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tab_r[i] <= SS_FREE;
      end
    end else begin
      upc_r    <= upc_nxt;
      strobe_r <= strobe_nxt;
      nus_r    <= nus_nxt;
      if (wr_en) begin
        tab_r[wr_addr] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    cnt_r   <= cnt_nxt;
    from_r  <= from_nxt;
    found_r <= found_nxt;
    in_r    <= in_nxt;
    out_r   <= out_nxt;
  end

  `RRPT_ASSERT_SAME(a_idle_on_result, out_strobe, !busy, "result while sequencer busy")
  `RRPT_ASSERT_NEXT(a_busy_after_accept, accept && (in_item.kind != KIND_RSVD), busy, "no step")
  `RRPT_ASSERT_SAME(a_no_from_id, out_strobe && res_yield && !out_item.from_valid, out_item.slot_id == 3'd0, "id")
  `RRPT_ASSERT_SAME(a_next_only_switch, out_strobe && (out_item.next_slot != 3'd0), (out_item.status == RS_SWITCHED), "next_slot set")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the round-robin process table: directed and random command beats against a predictor
module tb_top;
  import rrpt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_item;
  logic      out_strobe;
  out_beat_t out_item;

  slot_st_t    sched_state [SLOTS];
  int unsigned created_cnt;
  out_beat_t   pending_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en = 1'b1;

  round_robin_process_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Advances the slot table by one command; returns 1 if the command yields a result beat.
  function automatic bit schedule_step(input in_beat_t b, output out_beat_t r);
    int i;
    int from_idx;
    int probe;
    bit found;
    bit got;
    bit has_res;
    r       = '0;
    has_res = 1'b1;
    case (kind_t'(b.kind))
      KIND_CREATE: begin
        if (created_cnt < SLOTS) begin
          sched_state[created_cnt] = SS_IDLE;
          r.status  = RS_CREATED;
          r.slot_id = created_cnt[2:0];
          created_cnt++;
        end else begin
          r.status = RS_FULL;
        end
      end
      KIND_DESTROY: begin
        r.slot_id = b.target_slot;
        if (int'(b.target_slot) >= SLOTS || sched_state[b.target_slot] == SS_FREE) begin
          r.status = RS_NOT_CREATED;
        end else if (sched_state[b.target_slot] == SS_DESTROYED) begin
          r.status = RS_ALREADY;
        end else if (sched_state[b.target_slot] == SS_RUNNING) begin
          sched_state[b.target_slot] = SS_MARKED;
          r.status = RS_BLOCKED;
        end else begin
          sched_state[b.target_slot] = SS_DESTROYED;
          r.status = RS_DESTROYED;
        end
      end
      KIND_YIELD: begin
        from_idx = 0;
        found    = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!found && (sched_state[i] == SS_RUNNING || sched_state[i] == SS_MARKED)) begin
            from_idx = i;
            found    = 1'b1;
          end
        end
        probe = 0;
        if (found) begin
          sched_state[from_idx] = (sched_state[from_idx] == SS_MARKED) ? SS_DESTROYED : SS_IDLE;
          probe = (from_idx + 1) % SLOTS;
        end
        got = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (!got) begin
            if (sched_state[probe] == SS_IDLE) begin
              got = 1'b1;
              sched_state[probe] = SS_RUNNING;
              r.next_slot = probe[2:0];
            end else begin
              probe = (probe + 1) % SLOTS;
            end
          end
        end
        r.slot_id    = from_idx[2:0];
        r.from_valid = found;
        r.status     = got ? RS_SWITCHED : RS_NONE_RUN;
      end
      default: has_res = 1'b0;
    endcase
    return has_res;
  endfunction

  // One command beat; start is left high so a following beat can go straight out.
  task automatic send_cmd(input kind_t k, input logic [2:0] tgt);
    in_beat_t  b;
    out_beat_t exp_r;
    b.kind        = k;
    b.target_slot = tgt;
    while (idle_en && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
    if (schedule_step(b, exp_r))
      pending_q.push_back(exp_r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic flag_error(input string what, input out_beat_t exp_r);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%s: exp st %0d id %0d fv %0b nx %0d, got st %0d id %0d fv %0b nx %0d",
               what, exp_r.status, exp_r.slot_id, exp_r.from_valid, exp_r.next_slot,
               out_item.status, out_item.slot_id, out_item.from_valid, out_item.next_slot);
  endtask

  always @(posedge clk) begin
    out_beat_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        flag_error("unexpected result beat", '0);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_item.status !== exp_r.status || out_item.slot_id !== exp_r.slot_id ||
            out_item.from_valid !== exp_r.from_valid || out_item.next_slot !== exp_r.next_slot)
          flag_error("result mismatch", exp_r);
      end
    end
  end

  task automatic test_empty_table();
    send_cmd(KIND_YIELD, 3'd0);
    send_cmd(KIND_DESTROY, 3'd0);
    send_cmd(KIND_DESTROY, 3'd7);
    send_cmd(KIND_RSVD, 3'd5);
  endtask

  task automatic test_create_until_full();
    repeat (SLOTS + 1) send_cmd(KIND_CREATE, 3'd7);
  endtask

  task automatic test_yield_and_destroy();
    send_cmd(KIND_YIELD, 3'd0);
    send_cmd(KIND_YIELD, 3'd2);
    send_cmd(KIND_DESTROY, 3'd1);  // running: marked
    send_cmd(KIND_DESTROY, 3'd1);  // marked: destroyed
    send_cmd(KIND_YIELD, 3'd0);    // nothing running, search from slot 0
    send_cmd(KIND_DESTROY, 3'd0);
    send_cmd(KIND_YIELD, 3'd0);    // marked slot retired on yield
    send_cmd(KIND_DESTROY, 3'd3);
    send_cmd(KIND_DESTROY, 3'd3);
  endtask

  task automatic test_random_schedule(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    int          i;
    kind_t       kd;
    logic [2:0]  tgt;
    for (k = 0; k < n; k++) begin
      idle_en = !(k >= n / 3 && k < n / 2);
      pick    = $urandom_range(99);
      tgt     = 3'($urandom_range(7));
      if (pick < 2) begin
        kd = KIND_CREATE;
      end else if (pick < 4) begin
        kd = KIND_DESTROY;
        if (pick == 3) begin
          for (i = 0; i < SLOTS; i++)
            if (sched_state[i] == SS_RUNNING) tgt = i[2:0];
        end
      end else if (pick < 6) begin
        kd = KIND_RSVD;
      end else begin
        kd = KIND_YIELD;
      end
      send_cmd(kd, tgt);
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    foreach (sched_state[i]) sched_state[i] = SS_FREE;
    created_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    drain_results();
    test_create_until_full();
    drain_results();
    test_yield_and_destroy();
    drain_results();
    test_random_schedule(2000);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rrpt_pkg.sv
rtl/round_robin_process_table.sv
tb/tb_top.sv
